/* rtl/core/rgbycc_pkg.sv */
package rgbycc_pkg;

   // Default number of fraction bits of the Q-format samples.
   localparam int FRACTION_BITS_DEFAULT = 14;

   // Coefficients carry 24 fraction bits.
   localparam int COEF_BITS = 24;
   localparam int COEF_W    = 26;
   localparam int SAMPLE_W  = 16;
   localparam int RESULT_W  = 17;
   localparam int SCALE_W   = 16;
   localparam int PROD_W    = COEF_W + SAMPLE_W;
   localparam int ACC_W     = PROD_W + 2;

   localparam logic [SCALE_W-1:0] OUTPUT_SCALE_RESET = 16'd255;

   // Configuration register indexes.
   localparam logic CSR_DIRECTION    = 1'b0;
   localparam logic CSR_OUTPUT_SCALE = 1'b1;

   // Direction codes.
   localparam logic DIR_TO_YPBPR = 1'b0;
   localparam logic DIR_TO_RGB   = 1'b1;

   // BT.601 coefficients, rounded to nearest with 24 fraction bits.
   localparam logic signed [COEF_W-1:0] K_YR  = 26'sd5016388;
   localparam logic signed [COEF_W-1:0] K_YG  = 26'sd9848226;
   localparam logic signed [COEF_W-1:0] K_YB  = 26'sd1912603;
   localparam logic signed [COEF_W-1:0] K_PBR = 26'sd2830920;
   localparam logic signed [COEF_W-1:0] K_PBG = 26'sd5557688;
   localparam logic signed [COEF_W-1:0] K_HALF = 26'sd8388608;
   localparam logic signed [COEF_W-1:0] K_PRG = 26'sd7024419;
   localparam logic signed [COEF_W-1:0] K_PRB = 26'sd1364189;
   localparam logic signed [COEF_W-1:0] K_RPR = 26'sd23521657;
   localparam logic signed [COEF_W-1:0] K_GPB = 26'sd5773644;
   localparam logic signed [COEF_W-1:0] K_GPR = 26'sd11981214;
   localparam logic signed [COEF_W-1:0] K_BPB = 26'sd29729227;
   localparam logic signed [COEF_W-1:0] K_ONE = 26'sd16777216;
   localparam logic signed [COEF_W-1:0] K_ZERO = 26'sd0;

   // Matrix entry for output row and input column in the given direction.
   function automatic logic signed [COEF_W-1:0] coef(input logic dir,
                                                     input logic [1:0] row,
                                                     input logic [1:0] col);
      logic signed [COEF_W-1:0] k;
      k = K_ZERO;
      if (dir == DIR_TO_YPBPR) begin
         case ({row, col})
            4'b00_00: k = K_YR;
            4'b00_01: k = K_YG;
            4'b00_10: k = K_YB;
            4'b01_00: k = -K_PBR;
            4'b01_01: k = -K_PBG;
            4'b01_10: k = K_HALF;
            4'b10_00: k = K_HALF;
            4'b10_01: k = -K_PRG;
            4'b10_10: k = -K_PRB;
            default:  k = K_ZERO;
         endcase
      end else begin
         case ({row, col})
            4'b00_00: k = K_ONE;
            4'b00_10: k = K_RPR;
            4'b01_00: k = K_ONE;
            4'b01_01: k = -K_GPB;
            4'b01_10: k = -K_GPR;
            4'b10_00: k = K_ONE;
            4'b10_01: k = K_BPB;
            default:  k = K_ZERO;
         endcase
      end
      return k;
   endfunction

endpackage

/* rtl/core/rgb_ypbpr_color_converter_unit.sv */
// An accepted request beat passes through five register stages to its
// response beat, each stage holding one beat. Throughput: one beat per cycle
// while rsp_ready is high; a stalled stage only holds back the stages in front of it.
// Reset (synchronous, active high) empties the pipeline and sets direction
// to RGB-to-YPbPr and the output scale to 255.
module rgb_ypbpr_color_converter_unit #(
   parameter int FRACTION_BITS = rgbycc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel: one pixel per beat.
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [rgbycc_pkg::SAMPLE_W-1:0] req_first_in,
   input  logic signed [rgbycc_pkg::SAMPLE_W-1:0] req_second_in,
   input  logic signed [rgbycc_pkg::SAMPLE_W-1:0] req_third_in,
   // Response channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [rgbycc_pkg::RESULT_W-1:0] rsp_first_out,
   output logic signed [rgbycc_pkg::RESULT_W-1:0] rsp_second_out,
   output logic signed [rgbycc_pkg::RESULT_W-1:0] rsp_third_out,
   // Configuration write port.
   input  logic                                   csr_write_enable,
   input  logic                                   csr_index,
   input  logic [rgbycc_pkg::SCALE_W-1:0]         csr_write_data
);

   localparam int PROD_W = rgbycc_pkg::PROD_W;
   localparam int ACC_W  = rgbycc_pkg::ACC_W;
   localparam int CB     = rgbycc_pkg::COEF_BITS;
   localparam int SW     = rgbycc_pkg::SCALE_W;
   localparam int RW     = rgbycc_pkg::RESULT_W;
   // Unity in the accumulator is 2^(FRACTION_BITS + 24); a clamped value
   // therefore needs FRACTION_BITS + 25 bits.
   localparam int CLAMP_W = FRACTION_BITS + CB + 1;
   localparam int EXT_W   = (CLAMP_W + 1 > ACC_W) ? CLAMP_W + 1 : ACC_W;
   localparam int HI_W    = CLAMP_W - CB;
   localparam int PH_W    = HI_W + SW;
   localparam int PL_W    = CB + SW;
   localparam int SUM_W   = PH_W + 1;
   localparam logic signed [EXT_W-1:0] ONE_EXT = EXT_W'(1) << (FRACTION_BITS + CB);

   // Configuration registers.
   logic          direction_ff;
   logic [SW-1:0] output_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff    <= rgbycc_pkg::DIR_TO_YPBPR;
         output_scale_ff <= rgbycc_pkg::OUTPUT_SCALE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rgbycc_pkg::CSR_DIRECTION:    direction_ff    <= csr_write_data[0];
            rgbycc_pkg::CSR_OUTPUT_SCALE: output_scale_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Stage valid bits and the per-stage advance terms. A stage may load when
   // it is empty or when its own beat moves on in the same cycle, so bubbles
   // are squeezed out while the response side stalls.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;

   assign adv5 = !v5_ff || rsp_ready;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   // Stage 1: nine coefficient products. The direction selects the matrix;
   // the inverse matrix has unity on the luma column and zeros where a
   // chroma term is absent.
   logic signed [PROD_W-1:0] prod_in [3][3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic                     dir1_ff;
   logic signed [rgbycc_pkg::SAMPLE_W-1:0] sample [3];

   assign sample[0] = req_first_in;
   assign sample[1] = req_second_in;
   assign sample[2] = req_third_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = PROD_W'(rgbycc_pkg::coef(direction_ff, 2'(r), 2'(c)))
                          * PROD_W'(sample[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         prod_ff <= prod_in;
         dir1_ff <= direction_ff;
      end
   end

   // Stage 2: exact sums of each row.
   logic signed [ACC_W-1:0] acc_in [3];
   logic signed [ACC_W-1:0] acc_ff [3];
   logic                    dir2_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1])
                   + ACC_W'(prod_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         acc_ff  <= acc_in;
         dir2_ff <= dir1_ff;
      end
   end

   // Stage 3: the forward result is the sum shifted down by 24 with
   // truncation toward minus infinity; the inverse path clamps to [0, 1.0].
   logic signed [RW-1:0]      fwd_in [3];
   logic signed [RW-1:0]      fwd3_ff [3];
   logic        [CLAMP_W-1:0] clamp_in [3];
   logic        [CLAMP_W-1:0] clamp_ff [3];
   logic signed [EXT_W-1:0]   acc_ext [3];
   logic                      dir3_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         fwd_in[r]  = acc_ff[r][CB+RW-1:CB];
         acc_ext[r] = EXT_W'(acc_ff[r]);
         if (acc_ext[r] < 0) begin
            clamp_in[r] = '0;
         end else if (acc_ext[r] > ONE_EXT) begin
            clamp_in[r] = ONE_EXT[CLAMP_W-1:0];
         end else begin
            clamp_in[r] = acc_ext[r][CLAMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && v2_ff) begin
         fwd3_ff  <= fwd_in;
         clamp_ff <= clamp_in;
         dir3_ff  <= dir2_ff;
      end
   end

   // Stage 4: the clamped value times the output scale, split into a high
   // and a low part so that each multiplier stays narrow.
   logic [PH_W-1:0]      ph_in [3];
   logic [PL_W-1:0]      pl_in [3];
   logic [PH_W-1:0]      ph_ff [3];
   logic [PL_W-1:0]      pl_ff [3];
   logic signed [RW-1:0] fwd4_ff [3];
   logic                 dir4_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         ph_in[r] = PH_W'(clamp_ff[r][CLAMP_W-1:CB]) * PH_W'(output_scale_ff);
         pl_in[r] = PL_W'(clamp_ff[r][CB-1:0]) * PL_W'(output_scale_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv4 && v3_ff) begin
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         fwd4_ff <= fwd3_ff;
         dir4_ff <= dir3_ff;
      end
   end

   // Stage 5: recombine the partial products and drop the fraction. Only the
   // integer part of the low product can reach the result, so it is added
   // after its own shift by 24.
   logic [SUM_W-1:0]     sum [3];
   logic signed [RW-1:0] res_in [3];
   logic signed [RW-1:0] res_ff [3];
   logic                 dir5_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum[r] = SUM_W'(ph_ff[r]) + SUM_W'(pl_ff[r][PL_W-1:CB]);
         if (dir4_ff == rgbycc_pkg::DIR_TO_RGB) begin
            res_in[r] = RW'(sum[r] >> FRACTION_BITS);
         end else begin
            res_in[r] = fwd4_ff[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv5 && v4_ff) begin
         res_ff  <= res_in;
         dir5_ff <= dir4_ff;
      end
   end

   assign rsp_valid      = v5_ff;
   assign rsp_first_out  = res_ff[0];
   assign rsp_second_out = res_ff[1];
   assign rsp_third_out  = res_ff[2];

`ifndef ASSERT_OFF
   // An accepted request always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted request beat did not enter the first stage");

   // A response can only appear when the last stage before it held a beat.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(v4_ff))
      else $error("response beat appeared without a source beat");

   // Inverse results lie within [0, output scale].
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && dir5_ff == rgbycc_pkg::DIR_TO_RGB) |->
         (!rsp_first_out[RW-1] && rsp_first_out[SW-1:0] <= output_scale_ff &&
          !rsp_second_out[RW-1] && rsp_second_out[SW-1:0] <= output_scale_ff &&
          !rsp_third_out[RW-1] && rsp_third_out[SW-1:0] <= output_scale_ff))
      else $error("inverse result outside the output scale");

   // A zero scale forces all inverse results to zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && dir5_ff == rgbycc_pkg::DIR_TO_RGB && output_scale_ff == '0) |->
         (rsp_first_out == '0 && rsp_second_out == '0 && rsp_third_out == '0))
      else $error("non-zero inverse result with zero scale");
`endif

endmodule

/* tb/rgb_ypbpr_color_converter_unit_tb.sv */
`timescale 1ns / 100ps

// Keeps the expected pixels in acceptance order and checks each response beat
// against the oldest one.
class pixel_scoreboard;

   typedef struct packed {
      logic [rgbycc_pkg::RESULT_W-1:0] first_out;
      logic [rgbycc_pkg::RESULT_W-1:0] second_out;
      logic [rgbycc_pkg::RESULT_W-1:0] third_out;
   } pixel_type;

   localparam int FRAC  = rgbycc_pkg::FRACTION_BITS_DEFAULT;
   localparam int SHIFT = 24;

   // BT.601 matrix with 24 fraction bits.
   localparam longint C_Y_R  = 5016388;
   localparam longint C_Y_G  = 9848226;
   localparam longint C_Y_B  = 1912603;
   localparam longint C_PB_R = 2830920;
   localparam longint C_PB_G = 5557688;
   localparam longint C_HALF = 8388608;
   localparam longint C_PR_G = 7024419;
   localparam longint C_PR_B = 1364189;
   localparam longint C_R_PR = 23521657;
   localparam longint C_G_PB = 5773644;
   localparam longint C_G_PR = 11981214;
   localparam longint C_B_PB = 29729227;

   pixel_type expected_pixels[$];
   logic   direction;
   longint output_scale;
   int     mismatches;

   function new();
      direction    = rgbycc_pkg::DIR_TO_YPBPR;
      output_scale = 255;
      mismatches   = 0;
   endfunction

   function void write_register(logic index, logic [rgbycc_pkg::SCALE_W-1:0] value);
      if (index == rgbycc_pkg::CSR_DIRECTION) begin
         direction = value[0];
      end else begin
         output_scale = longint'(value);
      end
   endfunction

   // Saturates a sum to [0, 1.0], then scales it and truncates.
   function logic [rgbycc_pkg::RESULT_W-1:0] scale_clamped(longint acc);
      longint unity;
      unity = longint'(1) <<< (FRAC + SHIFT);
      if (acc < 0) acc = 0;
      if (acc > unity) acc = unity;
      return 17'((acc * output_scale) >>> (FRAC + SHIFT));
   endfunction

   function pixel_type convert_pixel(logic signed [15:0] a, logic signed [15:0] b,
                                     logic signed [15:0] c);
      longint la, lb, lc, luma;
      pixel_type p;
      la = a;
      lb = b;
      lc = c;
      if (direction == rgbycc_pkg::DIR_TO_YPBPR) begin
         // An arithmetic shift of the exact sum rounds toward minus infinity.
         p.first_out  = 17'((C_Y_R * la + C_Y_G * lb + C_Y_B * lc) >>> SHIFT);
         p.second_out = 17'((-C_PB_R * la - C_PB_G * lb + C_HALF * lc) >>> SHIFT);
         p.third_out  = 17'((C_HALF * la - C_PR_G * lb - C_PR_B * lc) >>> SHIFT);
      end else begin
         luma         = la <<< SHIFT;
         p.first_out  = scale_clamped(luma + C_R_PR * lc);
         p.second_out = scale_clamped(luma - C_G_PB * lb - C_G_PR * lc);
         p.third_out  = scale_clamped(luma + C_B_PB * lb);
      end
      return p;
   endfunction

   function void note_pixel(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c);
      expected_pixels.push_back(convert_pixel(a, b, c));
   endfunction

   function void compare_field(string name, logic [rgbycc_pkg::RESULT_W-1:0] want,
                               logic [rgbycc_pkg::RESULT_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   function void check_result(logic [rgbycc_pkg::RESULT_W-1:0] f,
                              logic [rgbycc_pkg::RESULT_W-1:0] s,
                              logic [rgbycc_pkg::RESULT_W-1:0] t);
      pixel_type want;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         $display("%0t: response beat with nothing expected, expected none, actual %h %h %h",
                  $time, f, s, t);
         return;
      end
      want = expected_pixels.pop_front();
      compare_field("first_out", want.first_out, f);
      compare_field("second_out", want.second_out, s);
      compare_field("third_out", want.third_out, t);
   endfunction

   function int pending();
      return expected_pixels.size();
   endfunction

endclass

module rgb_ypbpr_color_converter_unit_tb;

   localparam int SAMPLE_W        = rgbycc_pkg::SAMPLE_W;
   localparam int RESULT_W        = rgbycc_pkg::RESULT_W;
   localparam int SCALE_W         = rgbycc_pkg::SCALE_W;
   localparam int FRAC            = rgbycc_pkg::FRACTION_BITS_DEFAULT;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int RANDOM_PHASES   = 13;
   // The pipeline is five stages deep, so a few spare cycles cover its tail.
   localparam int DRAIN_CYCLES    = 12;
   // Far beyond the longest quiet stretch of a correct run, the long
   // receiver hold-off included.
   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_CYCLES     = 60;
   localparam int PRESSURE_PHASE  = 10;

   typedef enum int {NOMINAL, NEAR_EDGE, ANY_VALUE} sample_kind_type;

   // Every input is driven to a known value from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_W-1:0] req_first_in  = '0;
   logic signed [SAMPLE_W-1:0] req_second_in = '0;
   logic signed [SAMPLE_W-1:0] req_third_in  = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [RESULT_W-1:0] rsp_first_out;
   logic signed [RESULT_W-1:0] rsp_second_out;
   logic signed [RESULT_W-1:0] rsp_third_out;
   logic csr_write_enable = 1'b0;
   logic csr_index = rgbycc_pkg::CSR_DIRECTION;
   logic [SCALE_W-1:0] csr_write_data = '0;

   pixel_scoreboard board = new();

   // Chances, in per cent, that a side idles in a given cycle.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   // Cycles for which the receiver still has to hold off.
   int hold_left = 0;
   int quiet_cycles = 0;

   // Forward pixels: black, white, the primaries, the field extremes and a
   // small negative value where rounding toward minus infinity shows.
   int fwd_pixels [10][3] = '{
      '{0, 0, 0}, '{16384, 16384, 16384}, '{16384, 0, 0}, '{0, 16384, 0},
      '{0, 0, 16384}, '{32767, 32767, 32767}, '{-32768, -32768, -32768},
      '{32767, -32768, 32767}, '{-32768, 32767, -32768}, '{-1, -1, -1}
   };

   // Inverse pixels with the output scale each one is sent under: the
   // reset scale first, then the largest scale, the smallest one and the
   // zero scale that lies outside the nominal range. Several of them drive
   // the sums far past both ends of the clamp.
   int inv_pixels [14][3] = '{
      '{0, 0, 0}, '{16384, 0, 0}, '{8192, 0, 0}, '{32767, 32767, 32767},
      '{-32768, -32768, -32768}, '{8192, -32768, 32767}, '{16384, 8192, -8192},
      '{16384, 0, 0}, '{8192, 0, 0}, '{16383, 1, -1},
      '{16384, 0, 0}, '{16383, 0, 0},
      '{16384, 0, 0}, '{32767, 32767, -32768}
   };
   int inv_scales [14] = '{255, 255, 255, 255, 255, 255, 255,
                           65535, 65535, 65535, 1, 1, 0, 0};

   rgb_ypbpr_color_converter_unit #(
      .FRACTION_BITS(FRAC)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_in    (req_first_in),
      .req_second_in   (req_second_in),
      .req_third_in    (req_third_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_first_out   (rsp_first_out),
      .rsp_second_out  (rsp_second_out),
      .rsp_third_out   (rsp_third_out),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial forever #1 clock = ~clock;

   // Both channels are observed at the rising edge, before the block's own
   // registers update. An accepted request beat is predicted at once, and an
   // accepted response beat is checked against the oldest prediction. The
   // watchdog counts edges at which neither channel moves a beat.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         board.note_pixel(req_first_in, req_second_in, req_third_in);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_first_out, rsp_second_out, rsp_third_out);
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // The receiver decides its ready at each falling edge. A pending hold-off
   // keeps it low for a counted stretch, whatever the idle rate is.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offers one pixel, after any random idle cycles, and returns at the
   // falling edge after it has been accepted. Valid is left high, so that
   // back-to-back beats keep it high without a dip.
   task automatic send_pixel(input logic signed [SAMPLE_W-1:0] a,
                             input logic signed [SAMPLE_W-1:0] b,
                             input logic signed [SAMPLE_W-1:0] c);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_first_in  = a;
      req_second_in = b;
      req_third_in  = c;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stops offering and waits until every predicted pixel has come back.
   // Each pixel gives exactly one response, so the pipeline is then empty.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   // Writes a register for one cycle and keeps the predictor in step. Only
   // called while the block is idle.
   task automatic write_register(input logic index, input logic [SCALE_W-1:0] value);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = value;
      board.write_register(index, value);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Nominal samples span [0, 1.0] for colours and [-0.5, 0.5] for chroma.
   // Near-edge samples sit within a few units of the field limits, of zero,
   // of the chroma limits and of 1.0, where the clamp and the rounding turn.
   function automatic logic signed [SAMPLE_W-1:0] random_sample(sample_kind_type kind,
                                                                 bit chroma);
      int base;
      case (kind)
         NOMINAL: begin
            if (chroma) return SAMPLE_W'(int'($urandom_range(16384)) - 8192);
            return SAMPLE_W'($urandom_range(16384));
         end
         NEAR_EDGE: begin
            case ($urandom_range(5))
               0:       base = -32768;
               1:       base = -8192;
               2:       base = 0;
               3:       base = 8192;
               4:       base = 16384;
               default: base = 32767;
            endcase
            return SAMPLE_W'(base + int'($urandom_range(6)) - 3);
         end
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      sample_kind_type kind;
      int pick;
      int current_scale;
      logic dir;
      logic [SCALE_W-1:0] scale;

      // Synchronous reset, released at a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed forward pixels run under the reset settings, which checks
      // the reset direction.
      for (int i = 0; i < 10; i++) begin
         send_pixel(SAMPLE_W'(fwd_pixels[i][0]), SAMPLE_W'(fwd_pixels[i][1]),
                    SAMPLE_W'(fwd_pixels[i][2]));
      end

      // Directed inverse pixels. The scale is left at its reset value for the
      // first group and rewritten between groups while the block is idle.
      wait_idle();
      write_register(rgbycc_pkg::CSR_DIRECTION, SCALE_W'(rgbycc_pkg::DIR_TO_RGB));
      current_scale = 255;
      for (int i = 0; i < 14; i++) begin
         if (inv_scales[i] != current_scale) begin
            wait_idle();
            write_register(rgbycc_pkg::CSR_OUTPUT_SCALE, SCALE_W'(inv_scales[i]));
            current_scale = inv_scales[i];
         end
         send_pixel(SAMPLE_W'(inv_pixels[i][0]), SAMPLE_W'(inv_pixels[i][1]),
                    SAMPLE_W'(inv_pixels[i][2]));
      end

      // Random phases. Each one takes a fresh setting of both registers, the
      // extremes of the scale among them. In the first third the receiver idles
      // most, in the second the sender idles most and the rest runs flat out.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         if (p < 4) begin
            req_idle_pct = 21;
            rsp_idle_pct = 78;
         end else if (p < 8) begin
            req_idle_pct = 78;
            rsp_idle_pct = 21;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         dir = p[0] ? rgbycc_pkg::DIR_TO_RGB : rgbycc_pkg::DIR_TO_YPBPR;
         case (p % 5)
            0:       scale = 16'd255;
            1:       scale = 16'd65535;
            2:       scale = 16'd1;
            3:       scale = SCALE_W'($urandom_range(65535, 1));
            default: scale = SCALE_W'($urandom_range(16, 2));
         endcase
         write_register(rgbycc_pkg::CSR_DIRECTION, SCALE_W'(dir));
         write_register(rgbycc_pkg::CSR_OUTPUT_SCALE, scale);
         // In one flat-out phase the receiver holds off for a long stretch
         // while the sender keeps offering, so the pipeline fills and the
         // block has to stall its request channel.
         if (p == PRESSURE_PHASE) hold_left = HOLD_CYCLES;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            pick = $urandom_range(99);
            kind = (pick < 60) ? NOMINAL : (pick < 80) ? NEAR_EDGE : ANY_VALUE;
            send_pixel(random_sample(kind, 1'b0),
                       random_sample(kind, dir == rgbycc_pkg::DIR_TO_RGB),
                       random_sample(kind, dir == rgbycc_pkg::DIR_TO_RGB));
         end
      end

      // Wait for the last responses, then a little longer so that a stray
      // extra beat would still be caught.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
